### design/isocam_pkg.sv
// Package for the isometric camera transform unit.
// Holds map size, register reset values, request codes and the pan direction table.
// No dependencies.
`timescale 1ns / 1ps

package isocam_pkg;

  // Map size in tiles (each from 2 to 1024)
  localparam int unsigned MAP_WIDTH  = 512;
  localparam int unsigned MAP_HEIGHT = 512;

  // Field widths
  localparam int unsigned REQ_W   = 4;
  localparam int unsigned COORD_W = 20;
  localparam int unsigned HGT_W   = 17;
  localparam int unsigned RES_W   = 24;
  localparam int unsigned CAM_W   = 10;
  localparam int unsigned ROT_W   = 2;
  localparam int unsigned ZOOM_W  = 2;
  localparam int unsigned SCR_W   = 13;
  localparam int unsigned CFG_IDX_W = 1;

  // Wide signed working width for the coordinate math
  localparam int unsigned CALC_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  // Reset values
  localparam logic [SCR_W-1:0]  SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [SCR_W-1:0]  SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [CAM_W-1:0]  CAM_X_RST = CAM_W'(MAP_WIDTH / 2);
  localparam logic [CAM_W-1:0]  CAM_Y_RST = CAM_W'(MAP_HEIGHT / 2);
  localparam logic [CAM_W-1:0]  CAM_X_MAX = CAM_W'(MAP_WIDTH - 1);
  localparam logic [CAM_W-1:0]  CAM_Y_MAX = CAM_W'(MAP_HEIGHT - 1);
  localparam logic [ZOOM_W-1:0] ZOOM_RST  = 2'd1;
  localparam logic [ZOOM_W-1:0] ZOOM_MAX  = 2'd2;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_GOTO          = 4'd0,
    REQ_PAN_LEFT      = 4'd1,
    REQ_PAN_RIGHT     = 4'd2,
    REQ_PAN_UP        = 4'd3,
    REQ_PAN_DOWN      = 4'd4,
    REQ_ZOOM_IN       = 4'd5,
    REQ_ZOOM_OUT      = 4'd6,
    REQ_SET_ZOOM      = 4'd7,
    REQ_ROT_LEFT      = 4'd8,
    REQ_ROT_RIGHT     = 4'd9,
    REQ_PROJECT_TILE  = 4'd10,
    REQ_PROJECT_FINE  = 4'd11,
    REQ_UNPROJECT     = 4'd12
  } req_type_e;

  // Pan direction per [direction][rotation]: bit 1 = x moves up, bit 0 = y moves up
  // (a cleared bit means that coordinate steps down)
  localparam logic [1:0] PAN_DIR [4][4] = '{
    '{2'b01, 2'b11, 2'b10, 2'b00},   // left
    '{2'b10, 2'b00, 2'b01, 2'b11},   // right
    '{2'b00, 2'b01, 2'b11, 2'b10},   // up
    '{2'b11, 2'b10, 2'b00, 2'b01}    // down
  };

endpackage

### design/isometric_camera_transform_unit.sv
// Top level of the isometric camera transform unit.
// Each transaction passes the input register, then the result register.
// Throughput: one per cycle unless stalled; all math is shifts and adds on one pass.
// Reset (rst_ni, async, low): camera at map center, rotation 0, zoom 1,
// screen 640 x 480, both pipeline stages empty.
// Depends on isocam_pkg.
`timescale 1ns / 1ps

module isometric_camera_transform_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [isocam_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [isocam_pkg::SCR_W-1:0]        cfg_wdata_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [isocam_pkg::REQ_W-1:0]        req_type_i,
  input  logic signed [isocam_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [isocam_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [isocam_pkg::HGT_W-1:0] coord_z_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [isocam_pkg::RES_W-1:0] out_x_o,
  output logic signed [isocam_pkg::RES_W-1:0] out_y_o,
  output logic signed [isocam_pkg::RES_W-1:0] out_z_o,
  output logic [isocam_pkg::CAM_W-1:0]        cam_x_o,
  output logic [isocam_pkg::CAM_W-1:0]        cam_y_o,
  output logic [isocam_pkg::ROT_W-1:0]        rotation_o,
  output logic [isocam_pkg::ZOOM_W-1:0]       zoom_o
);

  import isocam_pkg::*;

  // Signed divide by 2^k, truncating toward zero
  function automatic logic signed [CALC_W-1:0] sdiv_pow2(
    input logic signed [CALC_W-1:0] v,
    input logic [3:0]               k
  );
    logic signed [CALC_W-1:0] bias;
    bias = v[CALC_W-1] ? ((CALC_W'(1) <<< k) - CALC_W'(1)) : '0;
    return (v + bias) >>> k;
  endfunction

  // Configuration registers
  logic [SCR_W-1:0] scr_w_q, scr_h_q;

  // Camera state
  logic [CAM_W-1:0]  cam_x_q, cam_x_d, cam_y_q, cam_y_d;
  logic [ROT_W-1:0]  rot_q, rot_d;
  logic [ZOOM_W-1:0] zoom_q, zoom_d;

  // Input stage
  logic                      in_valid_q;
  logic [REQ_W-1:0]          req_q;
  logic signed [COORD_W-1:0] cx_q, cy_q;
  logic signed [HGT_W-1:0]   cz_q;

  // Result stage
  logic                      out_valid_q;
  logic signed [RES_W-1:0]   res_x_q, res_x_d, res_y_q, res_y_d, res_z_q, res_z_d;
  logic [CAM_W-1:0]          res_cx_q, res_cy_q;
  logic [ROT_W-1:0]          res_rot_q;
  logic [ZOOM_W-1:0]         res_zoom_q;

  logic in_acc;
  logic adv;

  // Handshake: input stage moves on when the result register is free or drains
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= SCREEN_WIDTH_RST;
      scr_h_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCREEN_WIDTH:  scr_w_q <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: scr_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_type_i;
      cx_q  <= coord_x_i;
      cy_q  <= coord_y_i;
      cz_q  <= coord_z_i;
    end
  end

  // Working values
  logic signed [CALC_W-1:0] cx_s, cy_s, cz_s, w2_s, h2_s, camx_s, camy_s;
  logic signed [CALC_W-1:0] dx, dy, a_v, b_v, px, py, pz, hz, hterm;
  logic signed [CALC_W-1:0] t1, t2, t3, mx, my;
  logic [ZOOM_W-1:0]        zl;
  logic [3:0]               kx, ky;
  logic                     fine, neg;
  logic [1:0]               pan;

  // Camera update and result computation
  always_comb begin
    cx_s   = CALC_W'(cx_q);
    cy_s   = CALC_W'(cy_q);
    cz_s   = CALC_W'(cz_q);
    w2_s   = CALC_W'(scr_w_q >> 1);
    h2_s   = CALC_W'(scr_h_q >> 1);
    zl     = (zoom_q > ZOOM_MAX) ? ZOOM_MAX : zoom_q;
    kx     = 4'd3 + 4'(zl);
    ky     = 4'd2 + 4'(zl);
    fine   = (req_q == REQ_PROJECT_FINE);
    neg    = rot_q[1];
    camx_s = fine ? (CALC_W'(cam_x_q) <<< 8) : CALC_W'(cam_x_q);
    camy_s = fine ? (CALC_W'(cam_y_q) <<< 8) : CALC_W'(cam_y_q);

    // projection
    dx  = cx_s - camx_s;
    dy  = cy_s - camy_s;
    a_v = rot_q[0] ? (-dx - dy) : (dx - dy);
    b_v = rot_q[0] ? (dx - dy)  : (dx + dy);
    hz  = (cz_s + (cz_s <<< 2)) <<< zl;     // height * 5 * 2^zoom
    if (fine) begin
      px    = sdiv_pow2((a_v - CALC_W'(256)) <<< kx, 4'd8);
      py    = sdiv_pow2(b_v <<< ky, 4'd8);
      pz    = b_v;
      hterm = sdiv_pow2(hz, 4'd8);
    end else begin
      px    = (a_v - CALC_W'(1)) <<< kx;
      py    = b_v <<< ky;
      pz    = b_v <<< 8;
      hterm = hz;
    end

    // unprojection
    t1 = sdiv_pow2(cx_s - w2_s, kx);
    t2 = sdiv_pow2(cy_s - h2_s, ky);
    t3 = sdiv_pow2(t2 - t1 + CALC_W'(1), 4'd1);
    case (rot_q)
      2'd0: begin mx = t1 + t3;    my = t3;         end
      2'd1: begin mx = t3;         my = -(t1 + t3); end
      2'd2: begin mx = -(t1 + t3); my = -t3;        end
      default: begin mx = -t3;     my = t1 + t3;    end
    endcase

    cam_x_d = cam_x_q;
    cam_y_d = cam_y_q;
    rot_d   = rot_q;
    zoom_d  = zoom_q;
    res_x_d = '0;
    res_y_d = '0;
    res_z_d = '0;
    pan     = PAN_DIR[2'(req_q - 4'd1)][rot_q];

    case (req_q)
      REQ_GOTO: begin
        if (cx_s < 0)                         cam_x_d = '0;
        else if (cx_s >= CALC_W'(MAP_WIDTH))  cam_x_d = CAM_X_MAX;
        else                                  cam_x_d = cx_s[CAM_W-1:0];
        if (cy_s < 0)                         cam_y_d = '0;
        else if (cy_s >= CALC_W'(MAP_HEIGHT)) cam_y_d = CAM_Y_MAX;
        else                                  cam_y_d = cy_s[CAM_W-1:0];
      end
      REQ_PAN_LEFT, REQ_PAN_RIGHT, REQ_PAN_UP, REQ_PAN_DOWN: begin
        // a step that would leave the map leaves that coordinate alone
        if (pan[1]) begin
          if (cam_x_q < CAM_X_MAX) cam_x_d = cam_x_q + 1'b1;
        end else begin
          if (cam_x_q != '0) cam_x_d = cam_x_q - 1'b1;
        end
        if (pan[0]) begin
          if (cam_y_q < CAM_Y_MAX) cam_y_d = cam_y_q + 1'b1;
        end else begin
          if (cam_y_q != '0) cam_y_d = cam_y_q - 1'b1;
        end
      end
      REQ_ZOOM_IN: begin
        if (zoom_q < ZOOM_MAX) zoom_d = zoom_q + 1'b1;
      end
      REQ_ZOOM_OUT: begin
        if (zoom_q != '0) zoom_d = zoom_q - 1'b1;
      end
      REQ_SET_ZOOM: begin
        if (cx_s < 0)                       zoom_d = '0;
        else if (cx_s > CALC_W'(ZOOM_MAX))  zoom_d = ZOOM_MAX;
        else                                zoom_d = cx_s[ZOOM_W-1:0];
      end
      REQ_ROT_LEFT:  rot_d = rot_q - 1'b1;
      REQ_ROT_RIGHT: rot_d = rot_q + 1'b1;
      REQ_PROJECT_TILE, REQ_PROJECT_FINE: begin
        res_x_d = RES_W'(w2_s + (neg ? -px : px));
        res_y_d = RES_W'(h2_s + (neg ? -py : py) - hterm);
        res_z_d = RES_W'(neg ? -pz : pz);
      end
      REQ_UNPROJECT: begin
        res_x_d = RES_W'(mx + CALC_W'(cam_x_q));
        res_y_d = RES_W'(my + CALC_W'(cam_y_q));
      end
      default: ;
    endcase
  end

  // Camera state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= CAM_X_RST;
      cam_y_q <= CAM_Y_RST;
      rot_q   <= '0;
      zoom_q  <= ZOOM_RST;
    end else if (adv) begin
      cam_x_q <= cam_x_d;
      cam_y_q <= cam_y_d;
      rot_q   <= rot_d;
      zoom_q  <= zoom_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_x_q    <= res_x_d;
      res_y_q    <= res_y_d;
      res_z_q    <= res_z_d;
      res_cx_q   <= cam_x_d;
      res_cy_q   <= cam_y_d;
      res_rot_q  <= rot_d;
      res_zoom_q <= zoom_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = res_x_q;
  assign out_y_o     = res_y_q;
  assign out_z_o     = res_z_q;
  assign cam_x_o     = res_cx_q;
  assign cam_y_o     = res_cy_q;
  assign rotation_o  = res_rot_q;
  assign zoom_o      = res_zoom_q;

endmodule

### design/isocam_checker.sv
// Port-level checker for the isometric camera transform unit, plus its bind.
// Depends on isocam_pkg and isometric_camera_transform_unit.
`timescale 1ns / 1ps

module isocam_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [isocam_pkg::RES_W-1:0]  out_x_o,
  input logic signed [isocam_pkg::RES_W-1:0]  out_y_o,
  input logic [isocam_pkg::CAM_W-1:0]         cam_x_o,
  input logic [isocam_pkg::CAM_W-1:0]         cam_y_o,
  input logic [isocam_pkg::ZOOM_W-1:0]        zoom_o
);

  import isocam_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o))
    else $error("result changed while stalled");

  // An accepted transaction should pass the input register and show up at the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("accepted transaction did not reach the output");

  // Camera never leaves the map
  a_cam_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cam_x_o <= CAM_X_MAX) && (cam_y_o <= CAM_Y_MAX))
    else $error("camera outside the map");

  // Zoom saturates at the top level
  a_zoom_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> zoom_o <= ZOOM_MAX)
    else $error("zoom above maximum");

endmodule

bind isometric_camera_transform_unit isocam_checker u_isocam_checker (.*);
